### rtl/mlt_pkg.sv
// ----------------------------------------------------------------------------
// mlt_pkg
// Shared types, constants and codes of the station address table with aging.
// ----------------------------------------------------------------------------
package mlt_pkg;

   // table geometry and field widths
   localparam int TABLE_DEPTH_DEF = 256;
   localparam int PORT_COUNT      = 64;
   localparam int MAC_W           = 48;
   localparam int PORT_W          = 6;
   localparam int STAMP_W         = 32;
   localparam int COUNT_W         = 9;
   localparam int PORT_CMP_W      = 9;
   localparam int CSR_IDX_W       = 2;
   localparam int CSR_DATA_W      = 32;

   localparam logic [MAC_W-1:0]      MAC_BROADCAST    = '1;
   localparam logic [STAMP_W-1:0]    MIN_LIFETIME_RST = 32'd300;
   localparam logic [COUNT_W-1:0]    COUNT_MAX        = '1;
   localparam logic [PORT_CMP_W-1:0] PORT_LIMIT       = PORT_CMP_W'(PORT_COUNT);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_LIFETIME = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEFAULT_PORT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DEFAULT_SET  = 2'd2;

   typedef enum logic [1:0] {
      OP_LEARN  = 2'd0,
      OP_LOOKUP = 2'd1,
      OP_SWEEP  = 2'd2,
      OP_TICK   = 2'd3
   } opcode_type;

   typedef struct packed {
      opcode_type          opcode;
      logic [MAC_W-1:0]    mac_address;
      logic [PORT_W-1:0]   source_port;
   } req_type;

   typedef struct packed {
      logic [PORT_W-1:0]   out_port;
      logic                port_valid;
      logic                is_broadcast;
      logic                hit;
      logic                dropped_full;
      logic [COUNT_W-1:0]  removed_count;
   } rsp_type;

   typedef struct packed {
      logic [MAC_W-1:0]    mac;
      logic [PORT_W-1:0]   port;
      logic [STAMP_W-1:0]  stamp;
   } entry_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DISPATCH,
      ST_SCAN,
      ST_DRAIN,
      ST_UPDATE
   } ctrl_state_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic clear_step;
      logic scan_step;
      logic finish;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic idx_last;
      logic direct;
   } status_type;

endpackage

### rtl/mac_learning_table_with_aging.sv
// ----------------------------------------------------------------------------
// mac_learning_table_with_aging
// Switch station address table: learn, lookup, age sweep and seconds tick.
// ----------------------------------------------------------------------------
//
//   channel   ports                                  direction  flow control
//   request   start, busy, req_item                  in         start & !busy
//   response  rsp_strobe, rsp_item                   out        none (1 cycle)
//   csr       csr_we, csr_index, csr_wdata           in         none
//
// - tick, broadcast lookup and ignored learn: no scan, dispatch then update
// - learn, lookup and age sweep: a scan through the single read port of the
//   table memories, one entry per cycle, then drain and update
// - after reset a clearing pass writes every used bit to zero with busy
//   high; csr writes are taken during it
// - the result strobe is high for one cycle and cannot be held off
//
module mac_learning_table_with_aging
   import mlt_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
   input  logic                  clock,
   input  logic                  reset,
   // request transaction
   input  logic                  start,
   output logic                  busy,
   input  req_type               req_item,
   // response transaction
   output logic                  rsp_strobe,
   output rsp_type               rsp_item,
   // register writes
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // command and status between sequencer and datapath
   cmd_type    cmd;
   status_type status;

   // sequencer: clear pass, dispatch, scan, drain, update
   mlt_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   // table memories, compare and aging logic, result register
   mlt_dp #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

endmodule

### rtl/mlt_ctrl.sv
// ----------------------------------------------------------------------------
// mlt_ctrl
// Sequencer: clearing pass, dispatch, table scan, drain and final update.
// ----------------------------------------------------------------------------
module mlt_ctrl
   import mlt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  status_type status,
   output cmd_type    cmd
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (status.idx_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            state_in = status.direct ? ST_UPDATE : ST_SCAN;
         end
         ST_SCAN: begin
            if (status.idx_last) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
         end
         ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
         end
         ST_UPDATE: begin
            cmd.finish = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

`ifndef SYNTHESIS
   // the final update always hands control back to idle
   a_update_to_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPDATE) |=> (state_ff == ST_IDLE))
      else $error("controller did not return to idle after update");

   // last scan read is always followed by the drain cycle
   a_scan_to_drain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && status.idx_last) |=> (state_ff == ST_DRAIN))
      else $error("scan end not followed by drain");

   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.clear_step, cmd.scan_step, cmd.finish}))
      else $error("more than one datapath command at once");
`endif

endmodule

### rtl/mlt_dp.sv
// ----------------------------------------------------------------------------
// mlt_dp
// Table memories, scan compare, aging check, registers and result register.
// ----------------------------------------------------------------------------
module mlt_dp
   import mlt_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output status_type            status,
   input  req_type               req_item,
   output logic                  rsp_strobe,
   output rsp_type               rsp_item,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int               IdxW    = $clog2(TABLE_DEPTH);
   localparam logic [IdxW-1:0]  IdxLast = IdxW'(TABLE_DEPTH - 1);

   // table storage
   entry_type entry_mem [TABLE_DEPTH];
   logic      used_mem  [TABLE_DEPTH];

   entry_type            ent_rd_ff;
   logic                 used_rd_ff;
   logic                 ent_we;
   logic [IdxW-1:0]      ent_wa;
   entry_type            ent_wd;
   logic                 used_we;
   logic [IdxW-1:0]      used_wa;
   logic                 used_wd;

   // item and scan state
   req_type              item_ff;
   logic [IdxW-1:0]      idx_ff;
   logic [IdxW-1:0]      idx_in;
   logic                 chk_valid_ff;
   logic [IdxW-1:0]      chk_idx_ff;
   logic                 found_ff;
   logic [IdxW-1:0]      found_idx_ff;
   logic [PORT_W-1:0]    found_port_ff;
   logic                 free_found_ff;
   logic [IdxW-1:0]      free_idx_ff;
   logic [COUNT_W-1:0]   removed_ff;
   logic [STAMP_W-1:0]   seconds_ff;

   // registers
   logic [STAMP_W-1:0]   min_lifetime_ff;
   logic [PORT_W-1:0]    default_port_ff;
   logic                 default_set_ff;

   rsp_type              rsp_in;
   rsp_type              rsp_item_ff;
   logic                 rsp_strobe_ff;

   logic                 is_bcast;
   logic                 learn_skip;
   logic                 match;
   logic                 vacant;
   logic                 aged;
   logic [STAMP_W-1:0]   age;

   assign is_bcast   = (item_ff.mac_address == MAC_BROADCAST);
   assign learn_skip = is_bcast || (PORT_CMP_W'(item_ff.source_port) >= PORT_LIMIT);

   assign status.idx_last = (idx_ff == IdxLast);
   assign status.direct   = (item_ff.opcode == OP_TICK) ||
                            ((item_ff.opcode == OP_LEARN) && learn_skip) ||
                            ((item_ff.opcode == OP_LOOKUP) && is_bcast);

   // compare on the entry read in the previous cycle
   assign age    = seconds_ff - ent_rd_ff.stamp;
   assign match  = chk_valid_ff && used_rd_ff && (ent_rd_ff.mac == item_ff.mac_address);
   assign vacant = chk_valid_ff && !used_rd_ff;
   assign aged   = chk_valid_ff && (item_ff.opcode == OP_SWEEP) && used_rd_ff &&
                   (age >= min_lifetime_ff);

   always_comb begin
      idx_in = idx_ff;
      if (cmd.load) begin
         idx_in = '0;
      end else if (cmd.clear_step || cmd.scan_step) begin
         idx_in = status.idx_last ? '0 : idx_ff + IdxW'(1);
      end
   end

   // result and final table write
   always_comb begin
      rsp_in       = '0;
      ent_we       = 1'b0;
      ent_wa       = found_idx_ff;
      ent_wd.mac   = item_ff.mac_address;
      ent_wd.port  = item_ff.source_port;
      ent_wd.stamp = seconds_ff;
      unique case (item_ff.opcode)
         OP_LEARN: begin
            if (!learn_skip) begin
               if (found_ff) begin
                  rsp_in.hit = 1'b1;
                  ent_we     = cmd.finish;
               end else if (free_found_ff) begin
                  ent_we = cmd.finish;
                  ent_wa = free_idx_ff;
               end else begin
                  rsp_in.dropped_full = 1'b1;
               end
            end
         end
         OP_LOOKUP: begin
            if (is_bcast) begin
               rsp_in.is_broadcast = 1'b1;
            end else if (found_ff) begin
               rsp_in.hit        = 1'b1;
               rsp_in.out_port   = found_port_ff;
               rsp_in.port_valid = 1'b1;
               ent_we            = cmd.finish;
               ent_wd.port       = found_port_ff;
            end else begin
               rsp_in.out_port   = default_port_ff;
               rsp_in.port_valid = default_set_ff &&
                                   (PORT_CMP_W'(default_port_ff) < PORT_LIMIT);
            end
         end
         OP_SWEEP: begin
            rsp_in.removed_count = removed_ff;
         end
         OP_TICK: begin
            rsp_in = '0;
         end
         default: begin
            rsp_in = '0;
         end
      endcase
   end

   // used-bit write: clearing pass, aging free, new learn
   always_comb begin
      used_we = 1'b0;
      used_wa = idx_ff;
      used_wd = 1'b0;
      priority if (cmd.clear_step) begin
         used_we = 1'b1;
      end else if (aged) begin
         used_we = 1'b1;
         used_wa = chk_idx_ff;
      end else if (cmd.finish && (item_ff.opcode == OP_LEARN) && !learn_skip &&
                   !found_ff && free_found_ff) begin
         used_we = 1'b1;
         used_wa = free_idx_ff;
         used_wd = 1'b1;
      end else begin
         used_we = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ent_we) begin
         entry_mem[ent_wa] <= ent_wd;
      end
      if (cmd.scan_step) begin
         ent_rd_ff <= entry_mem[idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (used_we) begin
         used_mem[used_wa] <= used_wd;
      end
      if (cmd.scan_step) begin
         used_rd_ff <= used_mem[idx_ff];
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         item_ff <= req_item;
      end
      if (cmd.scan_step) begin
         chk_idx_ff <= idx_ff;
      end
      if (match && !found_ff) begin
         found_idx_ff  <= chk_idx_ff;
         found_port_ff <= ent_rd_ff.port;
      end
      if (vacant && !free_found_ff) begin
         free_idx_ff <= chk_idx_ff;
      end
      if (cmd.finish) begin
         rsp_item_ff <= rsp_in;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff          <= '0;
         chk_valid_ff    <= 1'b0;
         found_ff        <= 1'b0;
         free_found_ff   <= 1'b0;
         removed_ff      <= '0;
         seconds_ff      <= '0;
         rsp_strobe_ff   <= 1'b0;
      end else begin
         idx_ff        <= idx_in;
         chk_valid_ff  <= cmd.scan_step;
         rsp_strobe_ff <= cmd.finish;
         if (cmd.load) begin
            found_ff      <= 1'b0;
            free_found_ff <= 1'b0;
            removed_ff    <= '0;
         end else begin
            if (match) found_ff <= 1'b1;
            if (vacant) free_found_ff <= 1'b1;
            if (aged && (removed_ff != COUNT_MAX)) begin
               removed_ff <= removed_ff + COUNT_W'(1);
            end
         end
         if (cmd.finish && (item_ff.opcode == OP_TICK)) begin
            seconds_ff <= seconds_ff + STAMP_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_lifetime_ff <= MIN_LIFETIME_RST;
         default_port_ff <= '0;
         default_set_ff  <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MIN_LIFETIME: min_lifetime_ff <= csr_wdata[STAMP_W-1:0];
            CSR_DEFAULT_PORT: default_port_ff <= csr_wdata[PORT_W-1:0];
            CSR_DEFAULT_SET:  default_set_ff  <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

`ifndef SYNTHESIS
   a_hit_xor_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> !(rsp_item_ff.hit && rsp_item_ff.dropped_full))
      else $error("result flags both hit and table full");

   a_bcast_alone: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && rsp_item_ff.is_broadcast) |->
         (!rsp_item_ff.port_valid && !rsp_item_ff.hit))
      else $error("broadcast result carries a port or a hit");

   a_count_only_sweep: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && (rsp_item_ff.removed_count != '0)) |->
         (item_ff.opcode == OP_SWEEP))
      else $error("removal count outside an age sweep");
`endif

endmodule
